FILE: rtl/srpd_pkg.sv
// Shared types and constants of the paletted sprite run-length decoder.
package srpd_pkg;

    localparam int PAL_DEPTH = 256;
    localparam int PAL_AW    = 8;
    localparam int RGBA_W    = 32;
    localparam int CNT_W     = 9;
    localparam int DIM_W     = 12;
    localparam int ENC_W     = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [0:0]       OP_PALETTE   = 1'b0;
    localparam logic [0:0]       OP_DATA      = 1'b1;
    localparam logic [ENC_W-1:0] ENC_RAW      = 2'd0;
    localparam logic [ENC_W-1:0] ENC_TYPE_LEN = 2'd1;
    localparam logic [7:0]       LITERAL_TYPE = 8'hFF;
    localparam logic [2:0]       LITERAL_CODE = 3'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENCODING = 2'd0,
        REG_WIDTH    = 2'd1,
        REG_HEIGHT   = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_SPAN    = 2'd1,
        CMD_LITERAL = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [PAL_AW-1:0]  slot;
        logic [RGBA_W-1:0]  rgba;
        logic [CNT_W-1:0]   count;
        logic               last;
    } t_cmd;

endpackage

FILE: rtl/srpd_item_if.sv
// Input item channel of the sprite decoder.
interface srpd_item_if
    import srpd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              operation;
    logic [PAL_AW-1:0] palette_slot;
    logic [RGBA_W-1:0] palette_rgba;
    logic [7:0]        data_byte;

    modport source (output valid, output operation, output palette_slot,
                    output palette_rgba, output data_byte, input ready);
    modport sink (input valid, input operation, input palette_slot,
                  input palette_rgba, input data_byte, output ready);
endinterface

FILE: rtl/srpd_span_if.sv
// Output span channel of the sprite decoder.
interface srpd_span_if
    import srpd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [RGBA_W-1:0] pixel_rgba;
    logic [CNT_W-1:0]  repeat_count;
    logic              row_done;
    logic              frame_done;

    modport source (output valid, output pixel_rgba, output repeat_count,
                    output row_done, output frame_done, input ready);
    modport sink (input valid, input pixel_rgba, input repeat_count,
                  input row_done, input frame_done, output ready);
endinterface

FILE: rtl/srpd_cfg_if.sv
// Configuration write channel of the sprite decoder.
interface srpd_cfg_if
    import srpd_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

FILE: rtl/srpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srpd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/srpd_queue.sv
// Short command queue between the parser and the span unit.
module srpd_queue
    import srpd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_slots [DEPTH];
    logic [PW-1:0] r_head, n_head, r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slots[r_head];

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_push) begin
            n_tail = (r_tail == PW'(DEPTH - 1)) ? '0 : r_tail + PW'(1);
        end
        if (i_pop) begin
            n_head = (r_head == PW'(DEPTH - 1)) ? '0 : r_head + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_tail] <= i_data;
        end
    end
endmodule

FILE: rtl/srpd_front.sv
// Parser that accepts items, tracks segment headers and queues commands.
module srpd_front
    import srpd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_restart,
    input  logic [ENC_W-1:0] i_encoding,
    srpd_item_if.sink        i_item,
    input  logic             i_full,
    output logic             o_push,
    output t_cmd             o_cmd
);
    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_LENGTH  = 3'b010,
        PH_LITERAL = 3'b100
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [7:0]       r_header, n_header;
    logic [CNT_W-1:0] r_left, n_left;
    logic             w_take;
    logic [7:0]       w_byte;

    assign i_item.ready = !i_full;
    assign w_take       = i_item.valid && !i_full;
    assign w_byte       = i_item.data_byte;

    always_comb begin
        n_phase     = r_phase;
        n_header    = r_header;
        n_left      = r_left;
        o_push      = 1'b0;
        o_cmd.kind  = CMD_SPAN;
        o_cmd.slot  = w_byte;
        o_cmd.rgba  = i_item.palette_rgba;
        o_cmd.count = CNT_W'(1);
        o_cmd.last  = 1'b0;
        if (w_take) begin
            if (i_item.operation == OP_PALETTE) begin
                o_cmd.kind = CMD_WRITE;
                o_cmd.slot = i_item.palette_slot;
                o_push     = 1'b1;
            end else if (i_encoding == ENC_RAW) begin
                n_phase = PH_HEADER;
                n_left  = '0;
                o_push  = 1'b1;
            end else if (r_phase == PH_LITERAL && r_left != '0) begin
                o_cmd.kind = CMD_LITERAL;
                o_cmd.last = (r_left == CNT_W'(1));
                o_push     = 1'b1;
                n_left     = r_left - CNT_W'(1);
                if (r_left == CNT_W'(1)) begin
                    n_phase = PH_HEADER;
                end
            end else if (i_encoding == ENC_TYPE_LEN) begin
                if (r_phase == PH_LENGTH) begin
                    if (r_header == LITERAL_TYPE) begin
                        n_left  = {1'b0, w_byte} + CNT_W'(1);
                        n_phase = PH_LITERAL;
                    end else begin
                        n_phase     = PH_HEADER;
                        o_cmd.slot  = r_header;
                        o_cmd.count = {1'b0, w_byte} + CNT_W'(1);
                        o_push      = 1'b1;
                    end
                end else begin
                    n_header = w_byte;
                    n_phase  = PH_LENGTH;
                end
            end else begin
                n_header = w_byte;
                if (w_byte[7:5] == LITERAL_CODE) begin
                    n_left  = CNT_W'(w_byte[4:0]) + CNT_W'(1);
                    n_phase = PH_LITERAL;
                end else begin
                    n_phase     = PH_HEADER;
                    o_cmd.slot  = {5'd0, w_byte[7:5]};
                    o_cmd.count = CNT_W'(w_byte[4:0]) + CNT_W'(1);
                    o_push      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_phase  <= PH_HEADER;
            r_header <= '0;
            r_left   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_header <= n_header;
            r_left   <= n_left;
        end
    end
endmodule

FILE: rtl/srpd_back.sv
// Span unit: palette storage, row clipping, row and frame counting, output register.
module srpd_back
    import srpd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_restart,
    input  logic [DIM_W-1:0] i_width,
    input  logic [DIM_W-1:0] i_height,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_pop,
    srpd_span_if.source      o_span
);
    logic             r_valid, r_row_done, r_frame_done;
    logic [CNT_W-1:0] r_count;
    logic [DIM_W-1:0] r_filled, n_filled, r_rows, n_rows;
    logic             r_discard, n_discard;
    logic [DIM_W-1:0] w_room, w_sum, w_rows_inc;
    logic [CNT_W-1:0] w_clip;
    logic             w_row_end, w_frame_end;
    logic             w_slot_free, w_is_span, w_emit, w_we;
    logic [RGBA_W-1:0] w_rdata;

    assign w_slot_free = !r_valid || o_span.ready;
    assign w_is_span   = (i_cmd.kind == CMD_SPAN) ||
                         (i_cmd.kind == CMD_LITERAL && !r_discard);
    assign o_pop       = i_cmd_valid && (!w_is_span || w_slot_free);
    assign w_emit      = i_cmd_valid && w_is_span && w_slot_free;
    assign w_we        = i_cmd_valid && (i_cmd.kind == CMD_WRITE);

    assign w_room      = i_width - r_filled;
    assign w_clip      = (DIM_W'(i_cmd.count) > w_room) ? w_room[CNT_W-1:0] : i_cmd.count;
    assign w_sum       = r_filled + DIM_W'(w_clip);
    assign w_row_end   = (w_sum >= i_width);
    assign w_rows_inc  = r_rows + DIM_W'(1);
    assign w_frame_end = w_row_end && (w_rows_inc >= i_height);

    always_comb begin
        n_filled  = r_filled;
        n_rows    = r_rows;
        n_discard = r_discard;
        if (w_emit) begin
            n_filled = w_row_end ? '0 : w_sum;
            if (w_row_end) begin
                n_rows = w_frame_end ? '0 : w_rows_inc;
            end
        end
        if (o_pop && i_cmd.kind == CMD_LITERAL) begin
            n_discard = r_discard ? !i_cmd.last : (w_row_end && !i_cmd.last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_filled  <= '0;
            r_rows    <= '0;
            r_discard <= 1'b0;
        end else begin
            if (w_emit) begin
                r_valid <= 1'b1;
            end else if (o_span.ready) begin
                r_valid <= 1'b0;
            end
            if (i_restart) begin
                r_filled  <= '0;
                r_rows    <= '0;
                r_discard <= 1'b0;
            end else begin
                r_filled  <= n_filled;
                r_rows    <= n_rows;
                r_discard <= n_discard;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_count      <= w_clip;
            r_row_done   <= w_row_end;
            r_frame_done <= w_frame_end;
        end
    end

    srpd_ram #(
        .WIDTH (RGBA_W),
        .DEPTH (PAL_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_cmd.slot),
        .i_wdata (i_cmd.rgba),
        .i_re    (w_emit),
        .i_raddr (i_cmd.slot),
        .o_rdata (w_rdata)
    );

    assign o_span.valid        = r_valid;
    assign o_span.pixel_rgba   = w_rdata;
    assign o_span.repeat_count = r_count;
    assign o_span.row_done     = r_row_done;
    assign o_span.frame_done   = r_frame_done;
endmodule

FILE: rtl/sprite_rle_palette_decoder.sv
// Top level of the paletted sprite run-length decoder.
//
//  Port      Dir  Role                       Payload
//  i_item    in   palette writes, data bytes operation, palette_slot, palette_rgba, data_byte
//  o_span    out  decoded RGBA spans         pixel_rgba, repeat_count, row_done, frame_done
//  i_cfg     in   register writes            index, wdata
//
// One item is taken per cycle while the queue is not full. A span's command is queued
// when its last byte is taken, then popped into the palette read and output registers.
// Reset is synchronous and active low and needs no clearing pass.
// A stalled output fills the command queue, after which i_item.ready drops.
module sprite_rle_palette_decoder
    import srpd_pkg::*;
#(
    parameter int MAX_DIMENSION = 2048,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srpd_item_if.sink   i_item,
    srpd_span_if.source o_span,
    srpd_cfg_if.sink    i_cfg
);
    localparam int               CAP     = (MAX_DIMENSION > 4095) ? 4095 : MAX_DIMENSION;
    localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(CAP);

    logic [ENC_W-1:0] r_encoding;
    logic [DIM_W-1:0] r_width, r_height;
    logic             w_restart, w_push, w_full, w_pop, w_empty;
    t_cmd             w_cmd_in, w_cmd_out;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_CAP) begin
            r = DIM_CAP;
        end
        return r;
    endfunction

    assign i_cfg.ready = 1'b1;

    always_comb begin
        w_restart = 1'b0;
        if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_ENCODING, REG_WIDTH, REG_HEIGHT: w_restart = 1'b1;
                default:                             w_restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_encoding <= ENC_RAW;
            r_width    <= DIM_W'(1);
            r_height   <= DIM_W'(1);
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_ENCODING: r_encoding <= i_cfg.wdata[ENC_W-1:0];
                REG_WIDTH:    r_width    <= clamp_dim(i_cfg.wdata);
                REG_HEIGHT:   r_height   <= clamp_dim(i_cfg.wdata);
                default:      r_encoding <= r_encoding;
            endcase
        end
    end

    srpd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (w_restart),
        .i_encoding (r_encoding),
        .i_item     (i_item),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_cmd      (w_cmd_in)
    );

    srpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_empty)
    );

    srpd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (w_restart),
        .i_width     (r_width),
        .i_height    (r_height),
        .i_cmd_valid (!w_empty),
        .i_cmd       (w_cmd_out),
        .o_pop       (w_pop),
        .o_span      (o_span)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("Command pushed into a full queue.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_empty))
        else $error("Command popped from an empty queue.");

    a_span_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_span.valid |-> (o_span.repeat_count != '0) &&
                         (!o_span.frame_done || o_span.row_done))
        else $error("Span with zero count or frame end without row end.");
`endif
endmodule
